FILE: rtl/ssc_pkg.sv
// Shared types and constants for the shadow slot cache policy block.
// Depends on nothing; every other file of the block imports it.
package ssc_pkg;

    localparam int TAG_W  = 16;
    localparam int TIME_W = 32;
    localparam int SLOT_W = 4;
    localparam int KIND_W = 2;

    localparam logic [KIND_W-1:0] KIND_HIT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLAIM = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EVICT = 2'd2;

    // Search token that walks down the row of slot cells.
    typedef struct packed {
        logic              active;
        logic [TAG_W-1:0]  tag;
        logic              hit;
        logic [TIME_W-1:0] hit_time;
        logic              free;
        logic              old;
        logic [TIME_W-1:0] old_time;
    } scan_t;

    // Update broadcast to all slot cells; the cell address travels beside it.
    typedef struct packed {
        logic              en;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] stamp;
    } slot_wr_t;

endpackage

FILE: rtl/ssc_req_if.sv
// Request channel of the shadow slot cache policy block.
// Depends on ssc_pkg for the field widths.
interface ssc_req_if
    import ssc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TAG_W-1:0]  owner_tag;
    logic [TIME_W-1:0] change_time;
    logic [TIME_W-1:0] now_time;
    logic              reload_flag;

    modport source (output valid, owner_tag, change_time, now_time, reload_flag,
                    input ready);
    modport sink (input valid, owner_tag, change_time, now_time, reload_flag,
                  output ready);
endinterface

FILE: rtl/ssc_rsp_if.sv
// Result channel of the shadow slot cache policy block.
// Depends on ssc_pkg for the field widths.
interface ssc_rsp_if
    import ssc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot_index;
    logic              redraw;
    logic [KIND_W-1:0] assign_kind;

    modport source (output valid, slot_index, redraw, assign_kind, input ready);
    modport sink (input valid, slot_index, redraw, assign_kind, output ready);
endinterface

FILE: rtl/ssc_cell.sv
// One slot of the table: valid bit, owner tag and timestamp, plus one stage
// of the search that walks the row. Depends on ssc_pkg.
module ssc_cell
    import ssc_pkg::*;
#(
    parameter int IDX  = 0,
    parameter int IDXW = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  scan_t           scan_in,
    input  logic [IDXW-1:0] hit_idx_in,
    input  logic [IDXW-1:0] free_idx_in,
    input  logic [IDXW-1:0] old_idx_in,
    output scan_t           scan_out,
    output logic [IDXW-1:0] hit_idx_out,
    output logic [IDXW-1:0] free_idx_out,
    output logic [IDXW-1:0] old_idx_out,
    input  slot_wr_t        wr,
    input  logic [IDXW-1:0] wr_idx
);
    localparam logic [IDXW-1:0] MY_IDX = IDXW'(IDX);

    logic              valid_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [TIME_W-1:0] time_reg;
    scan_t             scan_reg;
    scan_t             scan_next;
    logic [IDXW-1:0]   hit_idx_reg;
    logic [IDXW-1:0]   free_idx_reg;
    logic [IDXW-1:0]   old_idx_reg;
    logic              hit_here;
    logic              free_here;
    logic              old_here;
    logic              wr_here;

    assign hit_here  = valid_reg && (tag_reg == scan_in.tag) && !scan_in.hit;
    assign free_here = !valid_reg && !scan_in.free;
    assign old_here  = valid_reg && (!scan_in.old || (time_reg < scan_in.old_time));
    assign wr_here   = wr.en && (wr_idx == MY_IDX);

    always_comb
    begin
        scan_next = scan_in;
        if (hit_here)
        begin
            scan_next.hit      = 1'b1;
            scan_next.hit_time = time_reg;
        end
        if (free_here)
        begin
            scan_next.free = 1'b1;
        end
        if (old_here)
        begin
            scan_next.old      = 1'b1;
            scan_next.old_time = time_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            scan_reg  <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
            if (wr_here)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg  <= hit_here  ? MY_IDX : hit_idx_in;
        free_idx_reg <= free_here ? MY_IDX : free_idx_in;
        old_idx_reg  <= old_here  ? MY_IDX : old_idx_in;
        if (wr_here)
        begin
            tag_reg  <= wr.tag;
            time_reg <= wr.stamp;
        end
    end

    assign scan_out     = scan_reg;
    assign hit_idx_out  = hit_idx_reg;
    assign free_idx_out = free_idx_reg;
    assign old_idx_out  = old_idx_reg;
endmodule

FILE: rtl/shadow_slot_cache_policy_top.sv
// Shadow slot cache policy: a request walks a row of SLOT_COUNT slot cells,
// one cell per cycle; when the walk ends the chosen slot is rewritten if it redraws.
// The search result is registered after the last cell, and the response is registered when the walk ends.
// A new request is taken only in the idle state, so one request walks the row at a time.
// Reset clears all slot valid bits and the control state at once.
module shadow_slot_cache_policy_top
    import ssc_pkg::*;
#(
    parameter int SLOT_COUNT = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    ssc_req_if.sink   req,
    ssc_rsp_if.source rsp
);
    localparam int IDXW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [TIME_W-1:0] chg_reg;
    logic [TIME_W-1:0] now_reg;
    logic              reload_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic              res_hit_reg;
    logic              res_free_reg;
    logic [TIME_W-1:0] res_time_reg;
    logic [IDXW-1:0]   res_hit_idx_reg;
    logic [IDXW-1:0]   res_free_idx_reg;
    logic [IDXW-1:0]   res_old_idx_reg;
    logic              out_valid_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic              out_redraw_reg;
    logic [KIND_W-1:0] out_kind_reg;

    scan_t             scan_chain [SLOT_COUNT+1];
    logic [IDXW-1:0]   hit_chain  [SLOT_COUNT+1];
    logic [IDXW-1:0]   free_chain [SLOT_COUNT+1];
    logic [IDXW-1:0]   old_chain  [SLOT_COUNT+1];

    scan_t             scan_head;
    logic              req_beat;
    logic              out_free;
    logic              finish;
    logic [IDXW-1:0]   pick;
    logic [KIND_W-1:0] kind;
    logic              redraw;
    slot_wr_t          wr;

    assign req_beat  = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign finish    = (state_reg == ST_DONE) && out_free;

    always_comb
    begin
        scan_head        = '0;
        scan_head.active = req_beat;
        scan_head.tag    = req.owner_tag;
    end

    assign scan_chain[0] = scan_head;
    assign hit_chain[0]  = '0;
    assign free_chain[0] = '0;
    assign old_chain[0]  = '0;

    for (genvar i = 0; i < SLOT_COUNT; i++)
    begin : g_cell
        ssc_cell #(
            .IDX  (i),
            .IDXW (IDXW)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .scan_in      (scan_chain[i]),
            .hit_idx_in   (hit_chain[i]),
            .free_idx_in  (free_chain[i]),
            .old_idx_in   (old_chain[i]),
            .scan_out     (scan_chain[i+1]),
            .hit_idx_out  (hit_chain[i+1]),
            .free_idx_out (free_chain[i+1]),
            .old_idx_out  (old_chain[i+1]),
            .wr           (wr),
            .wr_idx       (pick)
        );
    end

    always_comb
    begin
        if (res_hit_reg)
        begin
            pick = res_hit_idx_reg;
            kind = KIND_HIT;
        end
        else if (res_free_reg)
        begin
            pick = res_free_idx_reg;
            kind = KIND_CLAIM;
        end
        else
        begin
            pick = res_old_idx_reg;
            kind = KIND_EVICT;
        end
        // A claimed or evicted slot is not a hit, so it always redraws.
        redraw   = !res_hit_reg || (chg_reg >= res_time_reg) || reload_reg;
        wr.en    = finish && redraw;
        wr.tag   = tag_reg;
        wr.stamp = now_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_beat)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_chain[SLOT_COUNT].active)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_beat)
        begin
            tag_reg    <= req.owner_tag;
            chg_reg    <= req.change_time;
            now_reg    <= req.now_time;
            reload_reg <= req.reload_flag;
        end
        if ((state_reg == ST_SCAN) && scan_chain[SLOT_COUNT].active)
        begin
            res_hit_reg      <= scan_chain[SLOT_COUNT].hit;
            res_free_reg     <= scan_chain[SLOT_COUNT].free;
            res_time_reg     <= scan_chain[SLOT_COUNT].hit_time;
            res_hit_idx_reg  <= hit_chain[SLOT_COUNT];
            res_free_idx_reg <= free_chain[SLOT_COUNT];
            res_old_idx_reg  <= old_chain[SLOT_COUNT];
        end
        if (finish)
        begin
            out_slot_reg   <= SLOT_W'(pick);
            out_redraw_reg <= redraw;
            out_kind_reg   <= kind;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.slot_index  = out_slot_reg;
    assign rsp.redraw      = out_redraw_reg;
    assign rsp.assign_kind = out_kind_reg;

    a_beat_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        req_beat |=> (state_reg == ST_SCAN))
        else $error("request beat did not start a scan");

    a_token_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_chain[SLOT_COUNT].active |-> (state_reg == ST_SCAN))
        else $error("search token left the row outside a scan");

    a_write_only_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (state_reg == ST_DONE) && out_free)
        else $error("slot update outside the finishing cycle");

    a_claim_redraws: assert property (@(posedge clk) disable iff (!rst_n)
        finish && !res_hit_reg |=> rsp.valid && rsp.redraw)
        else $error("claimed or evicted slot did not redraw");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.assign_kind == KIND_HIT) || (rsp.assign_kind == KIND_CLAIM)
            || (rsp.assign_kind == KIND_EVICT))
        else $error("illegal assignment kind");
endmodule
